// ===== hw/rtl/rational_arith_reduce_macros.svh =====
// assertion macros for the rational arithmetic block
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH

// implication checked every clock outside reset
`define RAR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked every clock outside reset
`define RAR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg
// shared codes for the rational arithmetic block
// ----------------------------------------------------------------------------
`default_nettype none
package rar_pkg;
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
endpackage
`default_nettype wire

// ===== hw/rtl/rar_divider.sv =====
// ----------------------------------------------------------------------------
// rar_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module rar_divider #(
  parameter int W = 33
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  dsr;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {r, q[W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        q    <= dividend;
        r    <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        if (diff[W]) begin
          r <= shifted[W-1:0];
          q <= {q[W-2:0], 1'b0};
        end else begin
          r <= diff[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
  assign rem  = r;
endmodule
`default_nettype wire

// ===== hw/rtl/rational_arith_reduce.sv =====
// rational_arith_reduce: fraction add/sub/mul/div with gcd reduction
// steps: cross products in S_MUL1/S_MUL2, sign and magnitudes in S_PREP, one
// divider pass per euclid step in S_GCD (at most about 46 steps), then final
// divisions by the gcd in S_DIVN/S_DIVD; zero denominator ends in S_MUL1, zero
// numerator in S_PREP; one item at a time, next taken once result is read
// reset: rst synchronous active high returns the sequencer to idle, no output
`default_nettype none
`include "rational_arith_reduce_macros.svh"
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic signed [15:0] num_a,
  input  wire logic signed [15:0] den_a,
  input  wire logic signed [15:0] num_b,
  input  wire logic signed [15:0] den_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [32:0] res_num,
  output logic [30:0]      res_den,
  output logic [1:0]       status
);
  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW + 1;  // magnitude of cross-product sum
  localparam int DW = 33;          // divider width covers the default range
  localparam int MW = (PW > DW) ? PW : DW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_PREP = 4'd3;
  localparam logic [3:0] S_GCD  = 4'd4;
  localparam logic [3:0] S_DIVN = 4'd5;
  localparam logic [3:0] S_DIVD = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0] state;
  logic [1:0] md;
  logic signed [OW-1:0] na, da, nb, db;
  logic signed [2*OW-1:0] p0, p1, dp;
  logic signed [2*OW+1:0] nsum;
  logic neg;
  logic [MW-1:0] mag, dm, gx, gy;
  logic [MW-1:0] div_a, div_b, quot, rem;
  logic div_start;
  logic div_busy;
  logic div_done;

  logic signed [OW-1:0] m_x, m_y;
  logic signed [2*OW-1:0] m_p;
  assign m_p = m_x * m_y;

  always_comb begin
    m_x = na;
    m_y = db;
    if (state == S_MUL1) begin
      if (md == rar_pkg::MODE_MUL) m_y = nb;
    end else begin
      m_x = da;
      m_y = nb;
    end
  end

  always_comb begin
    case (md)
      rar_pkg::MODE_ADD: nsum = (2*OW+2)'(p0) + (2*OW+2)'(p1);
      rar_pkg::MODE_SUB: nsum = (2*OW+2)'(p0) - (2*OW+2)'(p1);
      default:           nsum = (2*OW+2)'(p0);
    endcase
  end

  rar_divider #(.W(MW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .quot(quot), .rem(rem)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    div_start = 1'b0;
    div_a = gx;
    div_b = gy;
    case (state)
      S_GCD:  div_start = !div_busy && !div_done && (gy != '0);
      S_DIVN: begin
        div_a = mag;
        div_b = gx;
        div_start = !div_busy && !div_done;
      end
      S_DIVD: begin
        div_a = dm;
        div_b = gx;
        div_start = !div_busy && !div_done;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            md <= mode;
            na <= OW'(num_a);
            da <= OW'(den_a);
            nb <= OW'(num_b);
            db <= OW'(den_b);
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (da == '0 || db == '0) begin
            res_num <= '0; res_den <= '0; status <= rar_pkg::ST_ZERO_DEN;
            out_valid <= 1'b1; state <= S_OUT;
          end else if (md == rar_pkg::MODE_DIV && nb == '0) begin
            res_num <= '0; res_den <= '0; status <= rar_pkg::ST_DIV_ZERO;
            out_valid <= 1'b1; state <= S_OUT;
          end else begin
            p0 <= m_p;
            dp <= (2*OW)'(da * db);
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          p1 <= m_p;
          if (md == rar_pkg::MODE_DIV) dp <= m_p;
          state <= S_PREP;
        end
        S_PREP: begin
          if (nsum == '0) begin
            res_num <= '0; res_den <= 31'd1; status <= rar_pkg::ST_OK;
            out_valid <= 1'b1; state <= S_OUT;
          end else begin
            neg <= nsum[2*OW+1] ^ dp[2*OW-1];
            mag <= MW'(nsum[2*OW+1] ? -nsum : nsum);
            dm  <= MW'(dp[2*OW-1] ? -{dp[2*OW-1], dp} : {1'b0, dp});
            gx  <= MW'(nsum[2*OW+1] ? -nsum : nsum);
            gy  <= MW'(dp[2*OW-1] ? -{dp[2*OW-1], dp} : {1'b0, dp});
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // euclid: one remainder per divider pass
          if (gy == '0) state <= S_DIVN;
          else if (div_done) begin
            gx <= gy;
            gy <= rem;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            mag <= quot;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            res_num <= 33'(neg ? -mag : mag);
            res_den <= 31'(quot);
            status  <= rar_pkg::ST_OK;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RAR_ASSERT_IMP(a_ready_idle, clk, rst, out_valid, !in_ready, "ready while result pending")
  `RAR_ASSERT_IMP(a_ok_den, clk, rst, out_valid && status == rar_pkg::ST_OK, res_den != '0, "ok with zero den")
  `RAR_ASSERT_NXT(a_accept, clk, rst, in_valid && in_ready, state == S_MUL1, "accept lost")
  `RAR_ASSERT_IMP(a_err_den, clk, rst, out_valid && status != rar_pkg::ST_OK, res_den == '0, "error with den")
endmodule
`default_nettype wire
